>>> src/pbkdf_pkg.sv
// Shared types and constants for the PBKDF2 HMAC-SHA-512 engine.
// Holds the SHA-512 tables, the command and status structs and the message codes.
// No dependencies.
package pbkdf_pkg;

    typedef logic [7:0][63:0] t_h8;

    localparam int BLK_W = 8;

    localparam logic [1:0] CMD_PASSWORD = 2'd0;
    localparam logic [1:0] CMD_SALT     = 2'd1;
    localparam logic [1:0] CMD_START    = 2'd2;

    localparam logic REG_ITER = 1'b0;
    localparam logic REG_KLEN = 1'b1;

    localparam logic [63:0] IPAD_W  = {8{8'h36}};
    localparam logic [63:0] OPAD_W  = {8{8'h5c}};
    localparam logic [63:0] U_PAD_W = 64'h8000_0000_0000_0000;
    localparam logic [63:0] U_LEN_W = 64'd1536;

    // message kinds fed to the compression unit
    typedef enum logic [2:0] {
        MSG_PW_RAW, MSG_PW_FIN, MSG_PAD_I, MSG_PAD_O, MSG_SALT, MSG_U_CHAIN, MSG_U_INNER
    } t_msg;

    typedef enum logic [2:0] {
        CH_INIT, CH_LKH, CH_IPAD, CH_OPAD, CH_INNER
    } t_chain;

    typedef enum logic [2:0] {
        DST_LKH, DST_IPAD, DST_OPAD, DST_INNER, DST_CHAIN
    } t_dest;

    typedef struct packed {
        logic             pw_wr;
        logic             pw_latched;
        logic             latch;
        logic             salt_wr;
        logic             mark_set;
        logic             go;
        t_msg             kind;
        t_chain           chain;
        t_dest            dest;
        logic [BLK_W-1:0] blk;
        logic [3:0]       blk_num;
        logic             acc_first;
        logic             clear;
        logic             out_load;
        logic             out_err;
        logic [2:0]       out_j;
        logic [3:0]       out_cnt;
        logic             out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic             done;
        logic             len_full;
        logic             len_boundary;
        logic             long_pw;
        logic             ovf;
        logic             salt_full;
        logic [BLK_W-1:0] fin_last;
        logic [BLK_W-1:0] salt_last;
        logic             out_free;
    } t_dp_sts;

    localparam t_h8 INIT_H = {
        64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
        64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
    };

    localparam logic [63:0] K_TAB [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage

>>> src/pbkdf_core.sv
// SHA-512 compression unit: 16 message words loaded, then one round per cycle.
// Depends on pbkdf_pkg for the round constants and the chain type.
// Digest appears in o_digest with a one-cycle o_done pulse.
module pbkdf_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  pbkdf_pkg::t_h8   i_chain,
    input  logic             i_w_valid,
    input  logic [63:0]      i_w,
    output logic             o_done,
    output pbkdf_pkg::t_h8   o_digest
);
    import pbkdf_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_LOAD = 4'b0010,
        C_RUN  = 4'b0100,
        C_ADD  = 4'b1000
    } t_cstate;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    t_cstate r_state, n_state;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_done;
    t_h8         r_h, r_r, n_r;
    logic [15:0][63:0] r_w;
    logic [63:0] w_next, s0, s1, ch, maj, t1, t2;

    // round and schedule logic
    always_comb begin
        s1     = rotr(r_r[4], 14) ^ rotr(r_r[4], 18) ^ rotr(r_r[4], 41);
        ch     = (r_r[4] & r_r[5]) ^ (~r_r[4] & r_r[6]);
        t1     = r_r[7] + s1 + ch + K_TAB[r_cnt] + r_w[0];
        s0     = rotr(r_r[0], 28) ^ rotr(r_r[0], 34) ^ rotr(r_r[0], 39);
        maj    = (r_r[0] & r_r[1]) ^ (r_r[0] & r_r[2]) ^ (r_r[1] & r_r[2]);
        t2     = s0 + maj;
        w_next = r_w[0] + (rotr(r_w[1], 1) ^ rotr(r_w[1], 8) ^ (r_w[1] >> 7)) + r_w[9]
               + (rotr(r_w[14], 19) ^ rotr(r_w[14], 61) ^ (r_w[14] >> 6));
        n_r    = {r_r[6:4], r_r[3] + t1, r_r[2:0], t1 + t2};
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_state = C_LOAD;
                    n_cnt   = 7'd0;
                end
            end
            C_LOAD: begin
                if (i_w_valid) begin
                    n_cnt = r_cnt + 7'd1;
                    if (r_cnt == 7'd15) begin
                        n_state = C_RUN;
                        n_cnt   = 7'd0;
                    end
                end
            end
            C_RUN: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd79) begin
                    n_state = C_ADD;
                end
            end
            C_ADD: begin
                n_state = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_cnt   <= 7'd0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= (r_state == C_ADD);
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_start) begin
            r_h <= i_chain;
            r_r <= i_chain;
        end
        if (r_state == C_LOAD && i_w_valid) begin
            r_w <= {i_w, r_w[15:1]};
        end
        if (r_state == C_RUN) begin
            r_r <= n_r;
            r_w <= {w_next, r_w[15:1]};
        end
        if (r_state == C_ADD) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_r[i];
            end
        end
    end

    assign o_done   = r_done;
    assign o_digest = r_h;

endmodule

>>> src/pbkdf_dp.sv
// Datapath: password and salt buffers, pad and chain registers, message word
// builder, compression unit and result register. Depends on pbkdf_pkg, pbkdf_core.
module pbkdf_dp #(
    parameter int MAX_SALT_BYTES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pbkdf_pkg::t_dp_cmd i_cmd,
    output pbkdf_pkg::t_dp_sts o_sts,
    input  logic [7:0]         i_data_byte,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [63:0]        o_key_word,
    output logic [3:0]         o_byte_count,
    output logic               o_last_word,
    output logic               o_error_flag
);
    import pbkdf_pkg::*;

    localparam int SWD  = (MAX_SALT_BYTES + 7) / 8;
    localparam int SAW  = (SWD > 1) ? $clog2(SWD) : 1;
    localparam int SLA  = $clog2(MAX_SALT_BYTES + 1);
    localparam int SLW  = (SLA > SAW + 3) ? SLA : SAW + 3;
    localparam int PW   = 15;

    logic [15:0][63:0] r_pw;
    logic [31:0]       r_len;
    t_h8               r_lkh, r_ipad, r_opad, r_inner, r_chain, r_acc;
    logic [63:0]       r_salt [SWD];
    logic [63:0]       r_sdat;
    logic [SLW-1:0]    r_slen;
    logic              r_ovf;
    logic [7:0]        r_byte;

    t_msg              r_kind;
    t_dest             r_dest;
    logic [BLK_W-1:0]  r_blk;
    logic              r_feed;
    logic [4:0]        r_ft;
    logic              r_v;
    logic [3:0]        r_t;

    logic              r_ovalid;
    logic [63:0]       r_oword;
    logic [3:0]        r_ocnt;
    logic              r_olast, r_oerr;

    t_h8               chain_sel, digest;
    logic              core_done;
    logic [63:0]       w_word, dat_w, key_w, u_src;
    logic [11:0]       wi;
    logic              rd_en;
    logic [SAW-1:0]    rd_addr;
    logic [7:0]        fill;
    logic [PW-1:0]     ldat, mlen, p, pbase, salt_m;
    logic [63:0]       bits, omask;
    logic [BLK_W-1:0]  lastidx;
    logic [7:0]        wbyte, bsel;
    logic [SAW-1:0]    s_waddr;
    logic [2:0]        pw_lane, s_lane;

    // status back to the controller
    assign fill   = {1'b0, 7'(r_len - 32'd1)} + 8'd1;
    assign salt_m = PW'(r_slen) + PW'(4);
    always_comb begin
        o_sts              = '0;
        o_sts.done         = core_done;
        o_sts.len_full     = (r_len == 32'hffff_ffff);
        o_sts.len_boundary = (r_len != 32'd0) && (r_len[6:0] == 7'd0);
        o_sts.long_pw      = (r_len > 32'd128);
        o_sts.ovf          = r_ovf;
        o_sts.salt_full    = (r_slen >= SLW'(MAX_SALT_BYTES));
        o_sts.fin_last     = BLK_W'(((PW'(fill) + PW'(144)) >> 7) - PW'(1));
        o_sts.salt_last    = BLK_W'(((salt_m + PW'(144)) >> 7) - PW'(1));
        o_sts.out_free     = !r_ovalid || !i_out_stall;
    end

    // chain selection at start of a compression
    always_comb begin
        case (i_cmd.chain)
            CH_INIT:  chain_sel = INIT_H;
            CH_LKH:   chain_sel = r_lkh;
            CH_IPAD:  chain_sel = r_ipad;
            CH_OPAD:  chain_sel = r_opad;
            CH_INNER: chain_sel = r_inner;
            default:  chain_sel = INIT_H;
        endcase
    end

    pbkdf_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.go),
        .i_chain   (chain_sel),
        .i_w_valid (r_v),
        .i_w       (w_word),
        .o_done    (core_done),
        .o_digest  (digest)
    );

    // feed sequencer: issue 16 word reads, register, then present to the core
    assign wi      = {r_blk, r_ft[3:0]};
    assign rd_en   = r_feed && (wi < 12'(SWD));
    assign rd_addr = wi[SAW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feed <= 1'b0;
            r_ft   <= 5'd0;
            r_v    <= 1'b0;
        end else begin
            r_v <= r_feed;
            if (i_cmd.go) begin
                r_feed <= 1'b1;
                r_ft   <= 5'd0;
            end else if (r_feed) begin
                r_ft <= r_ft + 5'd1;
                if (r_ft == 5'd15) begin
                    r_feed <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t <= r_ft[3:0];
        if (i_cmd.go) begin
            r_kind <= i_cmd.kind;
            r_dest <= i_cmd.dest;
            r_blk  <= i_cmd.blk;
        end
    end

    // salt memory: byte writes, registered word read
    assign s_waddr = r_slen[SAW+2:3];
    assign s_lane  = ~r_slen[2:0];
    always_ff @(posedge i_clk) begin
        if (i_cmd.salt_wr) begin
            r_salt[s_waddr][{s_lane, 3'b000} +: 8] <= i_data_byte;
        end
    end
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_sdat <= r_salt[rd_addr];
        end
    end

    // message word builder
    always_comb begin
        pbase   = {r_blk, r_t, 3'b000};
        key_w   = r_len > 32'd128 ? (r_t[3] ? 64'd0 : r_lkh[r_t[2:0]]) : r_pw[r_t];
        u_src   = (r_kind == MSG_U_CHAIN) ? r_chain[r_t[2:0]] : r_inner[r_t[2:0]];
        if (r_kind == MSG_SALT) begin
            dat_w   = r_sdat;
            ldat    = PW'(r_slen);
            mlen    = salt_m;
            bits    = 64'(PW'(128) + salt_m) << 3;
            lastidx = o_sts.salt_last;
        end else begin
            dat_w   = r_pw[r_t];
            ldat    = PW'(fill);
            mlen    = PW'(fill);
            bits    = {29'd0, r_len, 3'b000};
            lastidx = o_sts.fin_last;
        end
        w_word = '0;
        for (int k = 0; k < 8; k++) begin
            p = pbase + PW'(k);
            if (p < ldat) begin
                bsel = dat_w[63 - 8 * k -: 8];
            end else if (p < mlen) begin
                bsel = (p == mlen - PW'(1)) ? {4'd0, i_cmd.blk_num} : 8'd0;
            end else if (p == mlen) begin
                bsel = 8'h80;
            end else begin
                bsel = 8'd0;
            end
            w_word[63 - 8 * k -: 8] = bsel;
        end
        if (r_blk == lastidx && r_t == 4'd15) begin
            w_word = bits;
        end
        case (r_kind)
            MSG_PW_RAW:  w_word = r_pw[r_t];
            MSG_PAD_I:   w_word = key_w ^ IPAD_W;
            MSG_PAD_O:   w_word = key_w ^ OPAD_W;
            MSG_U_CHAIN, MSG_U_INNER: begin
                if (!r_t[3]) begin
                    w_word = u_src;
                end else if (r_t == 4'd8) begin
                    w_word = U_PAD_W;
                end else if (r_t == 4'd15) begin
                    w_word = U_LEN_W;
                end else begin
                    w_word = 64'd0;
                end
            end
            default: begin
            end
        endcase
    end

    // digest write-back
    always_ff @(posedge i_clk) begin
        if (core_done) begin
            case (r_dest)
                DST_IPAD:  r_ipad  <= digest;
                DST_OPAD:  r_opad  <= digest;
                DST_INNER: r_inner <= digest;
                DST_CHAIN: begin
                    r_chain <= digest;
                    r_acc   <= i_cmd.acc_first ? digest : (r_acc ^ digest);
                end
                default: begin
                end
            endcase
        end
    end

    // job buffers: password block, lengths, long key hash, overflow mark
    assign pw_lane = ~r_len[2:0];
    assign wbyte   = i_cmd.pw_latched ? r_byte : i_data_byte;
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_byte <= i_data_byte;
        end
        if (!i_rst_n || i_cmd.clear) begin
            r_pw   <= '0;
            r_len  <= 32'd0;
            r_lkh  <= INIT_H;
            r_slen <= '0;
            r_ovf  <= 1'b0;
        end else begin
            if (i_cmd.pw_wr) begin
                r_pw[r_len[6:3]][{pw_lane, 3'b000} +: 8] <= wbyte;
                r_len <= r_len + 32'd1;
            end
            if (i_cmd.salt_wr) begin
                r_slen <= r_slen + SLW'(1);
            end
            if (i_cmd.mark_set) begin
                r_ovf <= 1'b1;
            end
            if (core_done && r_dest == DST_LKH) begin
                r_lkh <= digest;
            end
        end
    end

    // result register
    always_comb begin
        omask = '0;
        for (int k = 0; k < 8; k++) begin
            omask[63 - 8 * k -: 8] = (4'(k) < i_cmd.out_cnt) ? 8'hff : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_oword <= r_acc[i_cmd.out_j] & omask;
            r_ocnt  <= i_cmd.out_cnt;
            r_olast <= i_cmd.out_last;
            r_oerr  <= i_cmd.out_err;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_key_word   = r_oword;
    assign o_byte_count = r_ocnt;
    assign o_last_word  = r_olast;
    assign o_error_flag = r_oerr;

endmodule

>>> src/pbkdf_ctrl.sv
// Controller: request decode, configuration registers and the derivation sequence.
// Drives the datapath through t_dp_cmd and reads t_dp_sts. Depends on pbkdf_pkg.
module pbkdf_ctrl #(
    parameter int MAX_KEY_BYTES = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    output pbkdf_pkg::t_dp_cmd o_cmd,
    input  pbkdf_pkg::t_dp_sts i_sts
);
    import pbkdf_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_PWCMP = 12'b0000_0000_0010,
        S_PWWR  = 12'b0000_0000_0100,
        S_FIN   = 12'b0000_0000_1000,
        S_IPAD  = 12'b0000_0001_0000,
        S_OPAD  = 12'b0000_0010_0000,
        S_SALT  = 12'b0000_0100_0000,
        S_OUTER = 12'b0000_1000_0000,
        S_INNER = 12'b0001_0000_0000,
        S_EMIT  = 12'b0010_0000_0000,
        S_ERR   = 12'b0100_0000_0000,
        S_CLEAR = 12'b1000_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic             r_issued, n_issued;
    logic [BLK_W-1:0] r_sb, n_sb;
    logic [3:0]       r_blknum, n_blknum;
    logic [30:0]      r_it, n_it;
    logic [9:0]       r_emit, n_emit;
    logic [2:0]       r_j, n_j;
    logic [30:0]      r_iter;
    logic [9:0]       r_klen;

    logic             acc_in;
    logic [9:0]       klen, left;
    logic [3:0]       cnt;
    logic             last;
    logic [30:0]      iters;
    logic             busy_cmp;

    // configuration registers
    assign o_cfg_ready = (r_state == S_IDLE);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= 31'd2048;
            r_klen <= 10'd64;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ITER: r_iter <= i_cfg_data;
                REG_KLEN: r_klen <= i_cfg_data[9:0];
                default:  r_iter <= r_iter;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign acc_in     = i_in_valid && !o_in_stall;
    assign klen       = (r_klen > 10'(MAX_KEY_BYTES)) ? 10'(MAX_KEY_BYTES) : r_klen;
    assign left       = klen - r_emit;
    assign cnt        = (left < 10'd8) ? left[3:0] : 4'd8;
    assign last       = (11'(r_emit) + 11'(cnt)) >= 11'(klen);
    assign iters      = (r_iter == 31'd0) ? 31'd1 : r_iter;
    assign busy_cmp   = (r_state == S_PWCMP) || (r_state == S_FIN) || (r_state == S_IPAD)
                     || (r_state == S_OPAD) || (r_state == S_SALT) || (r_state == S_OUTER)
                     || (r_state == S_INNER);

    // sequence
    always_comb begin
        n_state  = r_state;
        n_issued = r_issued;
        n_sb     = r_sb;
        n_blknum = r_blknum;
        n_it     = r_it;
        n_emit   = r_emit;
        n_j      = r_j;
        o_cmd         = '0;
        o_cmd.kind    = MSG_PW_RAW;
        o_cmd.chain   = CH_INIT;
        o_cmd.dest    = DST_LKH;
        o_cmd.blk     = r_sb;
        o_cmd.blk_num = r_blknum;
        o_cmd.acc_first = (r_it == 31'd0);
        if (busy_cmp) begin
            o_cmd.go = !r_issued;
            n_issued = 1'b1;
            if (i_sts.done) begin
                n_issued = 1'b0;
            end
        end
        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    case (i_command)
                        CMD_PASSWORD: begin
                            if (i_sts.len_full) begin
                                o_cmd.mark_set = 1'b1;
                            end else if (i_sts.len_boundary) begin
                                o_cmd.latch = 1'b1;
                                n_state     = S_PWCMP;
                            end else begin
                                o_cmd.pw_wr = 1'b1;
                            end
                        end
                        CMD_SALT: begin
                            o_cmd.salt_wr  = !i_sts.salt_full;
                            o_cmd.mark_set = i_sts.salt_full;
                        end
                        CMD_START: begin
                            n_sb     = '0;
                            n_blknum = 4'd1;
                            n_it     = 31'd0;
                            n_emit   = 10'd0;
                            n_j      = 3'd0;
                            if (i_sts.ovf || klen == 10'd0) begin
                                n_state = S_ERR;
                            end else if (i_sts.long_pw) begin
                                n_state = S_FIN;
                            end else begin
                                n_state = S_IPAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PWCMP: begin
                o_cmd.chain = CH_LKH;
                if (i_sts.done) begin
                    n_state = S_PWWR;
                end
            end
            S_PWWR: begin
                o_cmd.pw_wr      = 1'b1;
                o_cmd.pw_latched = 1'b1;
                n_state          = S_IDLE;
            end
            S_FIN: begin
                o_cmd.kind  = MSG_PW_FIN;
                o_cmd.chain = CH_LKH;
                if (i_sts.done) begin
                    n_sb = r_sb + BLK_W'(1);
                    if (r_sb == i_sts.fin_last) begin
                        n_sb    = '0;
                        n_state = S_IPAD;
                    end
                end
            end
            S_IPAD: begin
                o_cmd.kind = MSG_PAD_I;
                o_cmd.dest = DST_IPAD;
                if (i_sts.done) begin
                    n_state = S_OPAD;
                end
            end
            S_OPAD: begin
                o_cmd.kind = MSG_PAD_O;
                o_cmd.dest = DST_OPAD;
                if (i_sts.done) begin
                    n_state = S_SALT;
                end
            end
            S_SALT: begin
                o_cmd.kind  = MSG_SALT;
                o_cmd.chain = (r_sb == '0) ? CH_IPAD : CH_INNER;
                o_cmd.dest  = DST_INNER;
                if (i_sts.done) begin
                    n_sb = r_sb + BLK_W'(1);
                    if (r_sb == i_sts.salt_last) begin
                        n_sb    = '0;
                        n_state = S_OUTER;
                    end
                end
            end
            S_OUTER: begin
                o_cmd.kind  = MSG_U_INNER;
                o_cmd.chain = CH_OPAD;
                o_cmd.dest  = DST_CHAIN;
                if (i_sts.done) begin
                    n_it    = r_it + 31'd1;
                    n_state = ((r_it + 31'd1) < iters) ? S_INNER : S_EMIT;
                end
            end
            S_INNER: begin
                o_cmd.kind  = MSG_U_CHAIN;
                o_cmd.chain = CH_IPAD;
                o_cmd.dest  = DST_INNER;
                if (i_sts.done) begin
                    n_state = S_OUTER;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_j    = r_j;
                    o_cmd.out_cnt  = cnt;
                    o_cmd.out_last = last;
                    n_emit         = r_emit + 10'(cnt);
                    n_j            = r_j + 3'd1;
                    if (last) begin
                        n_state = S_CLEAR;
                    end else if (r_j == 3'd7) begin
                        n_blknum = r_blknum + 4'd1;
                        n_it     = 31'd0;
                        n_sb     = '0;
                        n_state  = S_SALT;
                    end
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_err  = i_sts.ovf;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_state == S_PWCMP || r_state == S_FIN) begin
            o_cmd.dest = DST_LKH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_sb     <= '0;
            r_blknum <= 4'd0;
            r_it     <= 31'd0;
            r_emit   <= 10'd0;
            r_j      <= 3'd0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_sb     <= n_sb;
            r_blknum <= n_blknum;
            r_it     <= n_it;
            r_emit   <= n_emit;
            r_j      <= n_j;
        end
    end

    // a completion only arrives for a compression that was started
    a_done_awaited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.done |-> r_issued)
        else $error("compression done without a pending start");

    // a result is loaded only when the result register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

    // a start is issued once per compression
    a_single_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.go |=> !o_cmd.go)
        else $error("second start before completion");

    // the final result of a derivation is followed by clearing the buffers
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && o_cmd.out_last) |=> o_cmd.clear)
        else $error("buffers not cleared after the final result");

endmodule

>>> src/pbkdf2_hmac_sha512_engine.sv
// PBKDF2 HMAC-SHA-512 engine. Password and salt requests are taken while idle; a password
// byte opening a new 128-byte block holds the input while the previous block is hashed.
// A compression runs start, feed, 16 word loads, 80 rounds, final add and completion in the
// single shared SHA-512 unit.
// Reset is synchronous, active low: buffers empty, registers at their defaults.
module pbkdf2_hmac_sha512_engine #(
    parameter int MAX_SALT_BYTES = 256,
    parameter int MAX_KEY_BYTES  = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_key_word,
    output logic [3:0]  o_byte_count,
    output logic        o_last_word,
    output logic        o_error_flag,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [30:0] i_cfg_data
);
    import pbkdf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    pbkdf_ctrl #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    pbkdf_dp #(
        .MAX_SALT_BYTES (MAX_SALT_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_data_byte  (i_data_byte),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_key_word   (o_key_word),
        .o_byte_count (o_byte_count),
        .o_last_word  (o_last_word),
        .o_error_flag (o_error_flag)
    );

endmodule
